FILE: rtl/core/grid_first_fit_rect_placer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid placer
// Immediate-implication and next-cycle-implication checks on i_clk, disabled
// while i_rst_n is low. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_FIRST_FIT_RECT_PLACER_TOP_MACROS_SVH
`define GRID_FIRST_FIT_RECT_PLACER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define GFFRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gffrp: same-cycle check failed");
`define GFFRP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gffrp: next-cycle check failed");
`else
`define GFFRP_ASSERT_IMP(lbl, ante, cons)
`define GFFRP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/gffrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_pkg
// Shared sizes, codes, types and helpers of the grid rectangle placer.
// ----------------------------------------------------------------------------
package gffrp_pkg;

    localparam int MAX_COLS = 16;
    localparam int MAX_ROWS = 16;

    // fixed field widths
    localparam int FLD_W  = 5;
    localparam int CODE_W = 4;
    localparam int POS_W  = 4;

    localparam int DIM_W_C = $clog2(MAX_COLS + 1);
    localparam int DIM_W_R = $clog2(MAX_ROWS + 1);
    localparam int DIM_W   = (DIM_W_C > DIM_W_R) ? ((DIM_W_C > FLD_W) ? DIM_W_C : FLD_W)
                                                 : ((DIM_W_R > FLD_W) ? DIM_W_R : FLD_W);
    localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // register indexes
    localparam logic CFG_GRID_COLS = 1'b0;
    localparam logic CFG_GRID_ROWS = 1'b1;
    localparam logic [FLD_W-1:0] GRID_COLS_RST = FLD_W'(16);
    localparam logic [FLD_W-1:0] GRID_ROWS_RST = FLD_W'(16);

    // placement modes
    localparam logic MODE_SCAN  = 1'b0;
    localparam logic MODE_ALIGN = 1'b1;

    // alignment spots: row-major, top-left first
    localparam logic [CODE_W-1:0] SPOT_TL = CODE_W'(0);
    localparam logic [CODE_W-1:0] SPOT_TC = CODE_W'(1);
    localparam logic [CODE_W-1:0] SPOT_TR = CODE_W'(2);
    localparam logic [CODE_W-1:0] SPOT_ML = CODE_W'(3);
    localparam logic [CODE_W-1:0] SPOT_MC = CODE_W'(4);
    localparam logic [CODE_W-1:0] SPOT_MR = CODE_W'(5);
    localparam logic [CODE_W-1:0] SPOT_BL = CODE_W'(6);
    localparam logic [CODE_W-1:0] SPOT_BC = CODE_W'(7);
    localparam logic [CODE_W-1:0] SPOT_BR = CODE_W'(8);

    typedef struct packed {
        logic              found;
        logic [COL_AW-1:0] x;
    } t_fit;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
    } t_spot;

    localparam logic [MAX_COLS:0] SPAN_ONE = (MAX_COLS + 1)'(1);

    // w ones starting at column x
    function automatic logic [MAX_COLS-1:0] span_mask(input logic [DIM_W-1:0] x,
                                                      input logic [DIM_W-1:0] w);
        logic [MAX_COLS:0] ones;
        ones = (SPAN_ONE << w) - SPAN_ONE;
        return ones[MAX_COLS-1:0] << x;
    endfunction

    // caller guarantees w <= cols and h <= rows
    function automatic t_spot align_spot(input logic [CODE_W-1:0] code,
                                         input logic [DIM_W-1:0]  cols,
                                         input logic [DIM_W-1:0]  rows,
                                         input logic [DIM_W-1:0]  w,
                                         input logic [DIM_W-1:0]  h);
        t_spot            s;
        logic [DIM_W-1:0] dx;
        logic [DIM_W-1:0] dy;
        dx = cols - w;
        dy = rows - h;
        s  = '0;
        unique case (code) inside
            SPOT_ML, SPOT_MC, SPOT_MR: s.y = dy >> 1;
            SPOT_BL, SPOT_BC, SPOT_BR: s.y = dy;
            default:                   s.y = '0;
        endcase
        unique case (code) inside
            SPOT_TC, SPOT_MC, SPOT_BC: s.x = dx >> 1;
            SPOT_TR, SPOT_MR, SPOT_BR: s.x = dx;
            default:                   s.x = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/core/gffrp_occ_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_occ_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gffrp_occ_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

FILE: rtl/core/gffrp_fit_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_fit_scan
// Finds the leftmost column where a w-wide window of a row bitmap is free.
// ----------------------------------------------------------------------------
module gffrp_fit_scan import gffrp_pkg::*; (
    input  logic [MAX_COLS-1:0] i_occ,
    input  logic [DIM_W-1:0]    i_cols,
    input  logic [DIM_W-1:0]    i_width,
    output t_fit                o_fit
);

    logic [MAX_COLS-1:0] hit;

    always_comb begin
        for (int i = 0; i < MAX_COLS; i++) begin
            hit[i] = (((DIM_W + 1)'(i) + (DIM_W + 1)'(i_width)) <= (DIM_W + 1)'(i_cols))
                  && ((i_occ & span_mask(DIM_W'(i), i_width)) == '0);
        end
    end

    // lowest column wins
    always_comb begin
        o_fit = '0;
        for (int i = MAX_COLS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_fit.found = 1'b1;
                o_fit.x     = COL_AW'(i);
            end
        end
    end

endmodule

FILE: rtl/core/grid_first_fit_rect_placer_top.sv
`timescale 1ns / 1ps
// Grid rectangle placer. Keeps a MAX_ROWS x MAX_COLS occupancy bitmap (one
// RAM word per row) and answers each request beat on s_axis with exactly one
// result beat on m_axis. One request is worked on at a time; a new request is
// taken as soon as the previous one has been handed to the output register,
// even if that result has not yet been taken. Rows go through the single
// RAM read port, one row per cycle. A rejected request goes straight to the
// result; aligned mode marks the rows at the chosen spot. First-fit tries
// each candidate top row in turn, ORing its h rows and searching them for a
// free window, then marks the winning rows. When no top row fits, the result
// reports not placed. Clear-first is instant: per-row valid flops make all
// rows read as free. grid_cols and grid_rows may only be written while no
// request is in flight.
// ----------------------------------------------------------------------------
// grid_first_fit_rect_placer_top
// Occupancy-grid rectangle placer, first-fit scan or fixed alignment spot.
// ----------------------------------------------------------------------------
`include "grid_first_fit_rect_placer_top_macros.svh"

module grid_first_fit_rect_placer_top import gffrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,  // clear_first, block_width[5], block_height[5],
                                            // align_position[4], pad
    input  logic             s_axis_tuser,  // mode
    // result
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // placed, pos_x[4], pos_y[4], pad
    // configuration
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [FLD_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,   // OR rows y..y+h-1 into r_acc
        S_EVAL,   // search r_acc for a free window
        S_MARK,   // read-modify-write the chosen rows
        S_FIN     // hand result to output register
    } t_state;

    t_state              r_state;
    logic [MAX_ROWS-1:0] r_valid;
    logic [FLD_W-1:0]    r_grid_cols;
    logic [FLD_W-1:0]    r_grid_rows;

    logic [DIM_W-1:0]    r_w;
    logic [DIM_W-1:0]    r_h;
    logic [DIM_W-1:0]    r_cols;
    logic [DIM_W-1:0]    r_rows;
    logic [DIM_W-1:0]    r_y;
    logic [DIM_W-1:0]    r_idx;
    logic [DIM_W-1:0]    r_px;
    logic [DIM_W-1:0]    r_py;
    logic                r_pend;
    logic                r_rd_vld;
    logic                r_placed;
    logic [ROW_AW-1:0]   r_waddr;
    logic [MAX_COLS-1:0] r_acc;
    logic [MAX_COLS-1:0] r_mask;

    logic                r_out_vld;
    logic                r_out_placed;
    logic [POS_W-1:0]    r_out_x;
    logic [POS_W-1:0]    r_out_y;

    // request fields
    logic                in_mode;
    logic                in_clear;
    logic [DIM_W-1:0]    in_w;
    logic [DIM_W-1:0]    in_h;
    logic [CODE_W-1:0]   in_code;
    logic [DIM_W-1:0]    cols_cl;
    logic [DIM_W-1:0]    rows_cl;
    logic                dims_ok;
    t_spot               spot;

    logic [DIM_W-1:0]    n_row;
    logic [MAX_COLS-1:0] mem_rdata;
    logic [MAX_COLS-1:0] rd_occ;
    logic                mem_we;
    t_fit                fit;
    logic                out_free;

    assign in_mode  = s_axis_tuser;
    assign in_clear = s_axis_tdata[0];
    assign in_w     = DIM_W'(s_axis_tdata[5:1]);
    assign in_h     = DIM_W'(s_axis_tdata[10:6]);
    assign in_code  = s_axis_tdata[14:11];

    // sizes above the array are taken as the array size
    assign cols_cl = (DIM_W'(r_grid_cols) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                              : DIM_W'(r_grid_cols);
    assign rows_cl = (DIM_W'(r_grid_rows) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                              : DIM_W'(r_grid_rows);
    assign dims_ok = (in_w != '0) && (in_h != '0) && (in_w <= cols_cl) && (in_h <= rows_cl);
    assign spot    = align_spot(in_code, cols_cl, rows_cl, in_w, in_h);

    // row address: scan window base or marked rectangle base, plus row index
    assign n_row  = ((r_state == S_MARK) ? r_py : r_y) + r_idx;
    // rows not written since the last clear read as free
    assign rd_occ = r_rd_vld ? mem_rdata : '0;
    assign mem_we = (r_state == S_MARK) && r_pend;

    gffrp_occ_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_waddr),
        .i_wdata (rd_occ | r_mask),
        .i_raddr (n_row[ROW_AW-1:0]),
        .o_rdata (mem_rdata)
    );

    gffrp_fit_scan u_fit (
        .i_occ   (r_acc),
        .i_cols  (r_cols),
        .i_width (r_w),
        .o_fit   (fit)
    );

    assign out_free      = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out_y, r_out_x, r_out_placed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_grid_cols <= GRID_COLS_RST;
            r_grid_rows <= GRID_ROWS_RST;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[n_row[ROW_AW-1:0]];

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GRID_COLS: r_grid_cols <= i_cfg_wdata;
                    CFG_GRID_ROWS: r_grid_rows <= i_cfg_wdata;
                    default:       r_grid_cols <= r_grid_cols;
                endcase
            end

            // output register: loaded from S_FIN, emptied when taken
            if ((r_state == S_FIN) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (in_clear) begin
                            r_valid <= '0;
                        end
                        r_w    <= in_w;
                        r_h    <= in_h;
                        r_cols <= cols_cl;
                        r_rows <= rows_cl;
                        r_y    <= '0;
                        r_idx  <= '0;
                        r_acc  <= '0;
                        r_pend <= 1'b0;
                        if (!dims_ok) begin
                            r_placed <= 1'b0;
                            r_state  <= S_FIN;
                        end else if (in_mode == MODE_ALIGN) begin
                            r_px     <= spot.x;
                            r_py     <= spot.y;
                            r_mask   <= span_mask(spot.x, in_w);
                            r_placed <= 1'b1;
                            r_state  <= S_MARK;
                        end else begin
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pend) begin
                        r_acc <= r_acc | rd_occ;
                    end
                    if (r_idx < r_h) begin
                        r_idx  <= r_idx + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_idx <= '0;
                    r_acc <= '0;
                    if (fit.found) begin
                        r_px     <= DIM_W'(fit.x);
                        r_py     <= r_y;
                        r_mask   <= span_mask(DIM_W'(fit.x), r_w);
                        r_placed <= 1'b1;
                        r_state  <= S_MARK;
                    end else if ((r_y + r_h) < r_rows) begin
                        r_y     <= r_y + 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        r_placed <= 1'b0;
                        r_state  <= S_FIN;
                    end
                end
                S_MARK: begin
                    // each write lands in the cycle after its read; rows are distinct
                    if (r_pend) begin
                        r_valid[r_waddr] <= 1'b1;
                    end
                    if (r_idx < r_h) begin
                        r_waddr <= n_row[ROW_AW-1:0];
                        r_idx   <= r_idx + 1'b1;
                        r_pend  <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_placed <= r_placed;
                        r_out_x      <= r_placed ? r_px[POS_W-1:0] : '0;
                        r_out_y      <= r_placed ? r_py[POS_W-1:0] : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // marked rectangle always lies inside the grid in use
    `GFFRP_ASSERT_IMP(a_mark_in_grid, (r_state == S_MARK), (((DIM_W + 1)'(r_py) + (DIM_W + 1)'(r_h) <= (DIM_W + 1)'(r_rows)) && ((DIM_W + 1)'(r_px) + (DIM_W + 1)'(r_w) <= (DIM_W + 1)'(r_cols))))
    // scan window never runs past the bottom row
    `GFFRP_ASSERT_IMP(a_scan_window, (r_state == S_SCAN), ((DIM_W + 1)'(r_y) + (DIM_W + 1)'(r_h) <= (DIM_W + 1)'(r_rows)))
    // unplaced results report the origin
    `GFFRP_ASSERT_IMP(a_unplaced_zero, (m_axis_tvalid && !m_axis_tdata[0]), (m_axis_tdata[8:1] == '0))
    // an accepted request always starts work
    `GFFRP_ASSERT_NXT(a_accept_busy, (s_axis_tvalid && s_axis_tready), (r_state != S_IDLE))

endmodule
